### design/plkc_pkg.sv
// Shared constants for the pinned LRU kind cache: operation and status codes,
// fixed port widths and the relation key type. No dependencies.
package plkc_pkg;

    localparam int KEY_W       = 32;
    localparam int KIND_W      = 2;
    localparam int OP_W        = 3;
    localparam int STAT_W      = 3;
    localparam int SLOT_PORT_W = 8;
    localparam int CNT_PORT_W  = 9;
    localparam int CAP_W       = 9;
    // Cells per group; the lookup chain is registered at every group boundary
    localparam int GRP         = 8;

    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    localparam logic [OP_W-1:0] OP_PIN    = 3'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 3'd1;
    localparam logic [OP_W-1:0] OP_SET    = 3'd2;
    localparam logic [OP_W-1:0] OP_UNPIN  = 3'd3;
    localparam logic [OP_W-1:0] OP_FORGET = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK         = 3'd0;
    localparam logic [STAT_W-1:0] STAT_ALL_PINNED = 3'd1;
    localparam logic [STAT_W-1:0] STAT_FORGET_PIN = 3'd2;
    localparam logic [STAT_W-1:0] STAT_BAD_UNPIN  = 3'd3;
    localparam logic [STAT_W-1:0] STAT_PIN_SAT    = 3'd4;

    typedef struct packed {
        logic [KEY_W-1:0] space;
        logic [KEY_W-1:0] database;
        logic [KEY_W-1:0] relation;
    } key_t;

endpackage

### design/plkc_cell.sv
// One table entry of the pinned LRU kind cache: key, kind, pin count and LRU rank.
// Depends on plkc_pkg; chained with its neighbors inside plkc_grp.
module plkc_cell
    import plkc_pkg::*;
#(
    parameter int ENTRIES  = 256,
    parameter int PIN_BITS = 8,
    parameter int IDX      = 0
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic [$bits(key_t)+2+SLOT_PORT_W+$clog2(ENTRIES)-1:0] probe,
    input  logic [2*$clog2(ENTRIES)+$bits(key_t)+KIND_W+PIN_BITS+7+$clog2(ENTRIES)-1:0] cmd,
    input  logic [3+4*$clog2(ENTRIES)+PIN_BITS+KIND_W-1:0] chain_in,
    output logic [3+4*$clog2(ENTRIES)+PIN_BITS+KIND_W-1:0] chain_out
);

    localparam int SW = $clog2(ENTRIES);

    typedef struct packed {
        key_t                   key;
        logic                   unpin_mode;
        logic                   head_en;
        logic [SLOT_PORT_W-1:0] slot_in;
        logic [SW-1:0]          head_rank;
    } probe_t;

    typedef struct packed {
        logic                go;
        logic                ins_en;
        logic                kind_en;
        logic                pin_en;
        logic                append_en;
        logic [SW-1:0]       tgt_slot;
        key_t                key;
        logic [KIND_W-1:0]   kind;
        logic [PIN_BITS-1:0] pin;
        logic                inval_en;
        logic [SW-1:0]       inval_slot;
        logic                unlink_en;
        logic [SW-1:0]       unlink_rank;
    } cmd_t;

    typedef struct packed {
        logic                free_any;
        logic [SW-1:0]       free_idx;
        logic                hit_any;
        logic [SW-1:0]       hit_idx;
        logic [PIN_BITS-1:0] hit_pin;
        logic [KIND_W-1:0]   hit_kind;
        logic [SW-1:0]       hit_rank;
        logic                head_any;
        logic [SW-1:0]       head_idx;
    } chain_t;

    probe_t prb;
    cmd_t   cm;
    chain_t cin;
    chain_t cout;

    logic                valid_reg;
    key_t                key_reg;
    logic [KIND_W-1:0]   kind_reg;
    logic [PIN_BITS-1:0] pin_reg;
    logic [SW-1:0]       rank_reg;
    logic [SW-1:0]       rank_next;

    logic member;
    logic is_match;
    logic is_head;
    logic is_tgt;
    logic is_inval;

    assign prb = probe_t'(probe);
    assign cm  = cmd_t'(cmd);
    assign cin = chain_t'(chain_in);

    // Classify this entry against the broadcast probe
    assign member   = valid_reg && (pin_reg == '0);
    assign is_match = valid_reg && (prb.unpin_mode ? (int'(prb.slot_in) == IDX)
                                                   : (key_reg == prb.key));
    assign is_head  = prb.head_en && member && (rank_reg == prb.head_rank);
    assign is_tgt   = (cm.tgt_slot == SW'(IDX));
    assign is_inval = (cm.inval_slot == SW'(IDX));

    // Merge into the chain: first free slot wins, match and head are unique
    always_comb begin
        cout          = cin;
        cout.free_any = cin.free_any | ~valid_reg;
        cout.free_idx = cin.free_any ? cin.free_idx : SW'(IDX);
        cout.hit_any  = cin.hit_any | is_match;
        cout.head_any = cin.head_any | is_head;
        if (is_match) begin
            cout.hit_idx  = cin.hit_idx | SW'(IDX);
            cout.hit_pin  = cin.hit_pin | pin_reg;
            cout.hit_kind = cin.hit_kind | kind_reg;
            cout.hit_rank = cin.hit_rank | rank_reg;
        end
        if (is_head) begin
            cout.head_idx = cin.head_idx | SW'(IDX);
        end
    end

    assign chain_out = cout;

    // Advance the recency rank: close the gap of an unlinked entry, age on append
    always_comb begin
        rank_next = rank_reg;
        if (cm.append_en && is_tgt) begin
            rank_next = '0;
        end else if (member) begin
            rank_next = rank_reg - SW'(cm.unlink_en && (rank_reg > cm.unlink_rank))
                        + SW'(cm.append_en);
        end
    end

    // Hold the valid bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cm.go) begin
            if (cm.ins_en && is_tgt) begin
                valid_reg <= 1'b1;
            end else if (cm.inval_en && is_inval) begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Update the entry payload
    always_ff @(posedge aclk) begin
        if (cm.go) begin
            if (cm.ins_en && is_tgt) begin
                key_reg <= cm.key;
            end
            if (cm.kind_en && is_tgt) begin
                kind_reg <= cm.kind;
            end
            if (cm.pin_en && is_tgt) begin
                pin_reg <= cm.pin;
            end
            rank_reg <= rank_next;
        end
    end

endmodule

### design/plkc_grp.sv
// A group of GRP chained cells whose merged lookup word is registered at the end.
// Depends on plkc_pkg and plkc_cell.
module plkc_grp
    import plkc_pkg::*;
#(
    parameter int ENTRIES  = 256,
    parameter int PIN_BITS = 8,
    parameter int BASE     = 0
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic [$bits(key_t)+2+SLOT_PORT_W+$clog2(ENTRIES)-1:0] probe,
    input  logic [2*$clog2(ENTRIES)+$bits(key_t)+KIND_W+PIN_BITS+7+$clog2(ENTRIES)-1:0] cmd,
    output logic [3+4*$clog2(ENTRIES)+PIN_BITS+KIND_W-1:0] grp_word
);

    localparam int CHW = 3 + 4 * $clog2(ENTRIES) + PIN_BITS + KIND_W;

    logic [CHW-1:0] link [GRP+1];
    logic [CHW-1:0] grp_word_reg;

    assign link[0] = '0;

    // Chain the cells; slots past the table end pass the word through
    for (genvar j = 0; j < GRP; j++) begin : g_cell
        if (BASE + j < ENTRIES) begin : g_real
            plkc_cell #(
                .ENTRIES  (ENTRIES),
                .PIN_BITS (PIN_BITS),
                .IDX      (BASE + j)
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .probe     (probe),
                .cmd       (cmd),
                .chain_in  (link[j]),
                .chain_out (link[j+1])
            );
        end else begin : g_pad
            assign link[j+1] = link[j];
        end
    end

    // Register the group result
    always_ff @(posedge aclk) begin
        grp_word_reg <= link[GRP];
    end

    assign grp_word = grp_word_reg;

endmodule

### design/pinned_lru_kind_cache_top.sv
// Top level of the pinned LRU kind cache: control sequencer, group merge,
// counters and output register. Depends on plkc_pkg and plkc_grp.
//
//  channel  direction  handshake            word
//  s_       in         s_valid / s_ready    op, 96-bit key, kind_in, slot_in
//  m_       out        m_valid / m_ready    status, found, kind, slot, counts
//  cfg_     in         cfg_valid/cfg_ready  capacity_limit (always ready)
//
// One item at a time: accept, probe the cell row (compare and merge within
// each group of 8 cells), merge the groups, then execute and broadcast the update.
// The execute step waits while the output register holds a word not yet taken.
// Reset clears all valid bits at once, the counts, and sets capacity to 256.
module pinned_lru_kind_cache_top
    import plkc_pkg::*;
#(
    parameter int ENTRIES  = 256,
    parameter int PIN_BITS = 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [OP_W-1:0]         s_kind,
    input  logic [KEY_W-1:0]        s_key_space,
    input  logic [KEY_W-1:0]        s_key_database,
    input  logic [KEY_W-1:0]        s_key_relation,
    input  logic [KIND_W-1:0]       s_kind_in,
    input  logic [SLOT_PORT_W-1:0]  s_slot_in,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [STAT_W-1:0]       m_status,
    output logic                    m_found,
    output logic [KIND_W-1:0]       m_kind_out,
    output logic [SLOT_PORT_W-1:0]  m_slot_out,
    output logic                    m_evicted,
    output logic [CNT_PORT_W-1:0]   m_occupancy,
    output logic [CNT_PORT_W-1:0]   m_pinned_total,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CAP_W-1:0]        cfg_data
);

    localparam int SW   = $clog2(ENTRIES);
    localparam int CW   = $clog2(ENTRIES + 1);
    localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;
    localparam int NGRP = (ENTRIES + GRP - 1) / GRP;
    localparam logic [PIN_BITS-1:0] PIN_MAX = '1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MATCH = 2'd1;
    localparam logic [1:0] ST_SEL   = 2'd2;
    localparam logic [1:0] ST_EXEC  = 2'd3;

    typedef struct packed {
        key_t                   key;
        logic                   unpin_mode;
        logic                   head_en;
        logic [SLOT_PORT_W-1:0] slot_in;
        logic [SW-1:0]          head_rank;
    } probe_t;

    typedef struct packed {
        logic                go;
        logic                ins_en;
        logic                kind_en;
        logic                pin_en;
        logic                append_en;
        logic [SW-1:0]       tgt_slot;
        key_t                key;
        logic [KIND_W-1:0]   kind;
        logic [PIN_BITS-1:0] pin;
        logic                inval_en;
        logic [SW-1:0]       inval_slot;
        logic                unlink_en;
        logic [SW-1:0]       unlink_rank;
    } cmd_t;

    typedef struct packed {
        logic                free_any;
        logic [SW-1:0]       free_idx;
        logic                hit_any;
        logic [SW-1:0]       hit_idx;
        logic [PIN_BITS-1:0] hit_pin;
        logic [KIND_W-1:0]   hit_kind;
        logic [SW-1:0]       hit_rank;
        logic                head_any;
        logic [SW-1:0]       head_idx;
    } chain_t;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    logic [OP_W-1:0]     op_reg;
    key_t                key_reg;
    logic [KIND_W-1:0]   kind_in_reg;
    logic [SLOT_PORT_W-1:0] slot_in_reg;
    logic [CAP_W-1:0]    cap_reg;
    logic [CW-1:0]       valid_cnt_reg;
    logic [CW-1:0]       valid_cnt_next;
    logic [CW-1:0]       pinned_cnt_reg;
    logic [CW-1:0]       pinned_cnt_next;
    logic [CW-1:0]       lru_cnt;
    chain_t              sel_reg;
    chain_t              sel_next;
    chain_t              grp_word [NGRP];
    probe_t              prb;
    cmd_t                cm;

    logic                   m_valid_reg;
    logic [STAT_W-1:0]      status_reg;
    logic                   found_reg;
    logic [KIND_W-1:0]      kind_out_reg;
    logic [SLOT_PORT_W-1:0] slot_out_reg;
    logic                   evicted_reg;

    logic [STAT_W-1:0]      status_next;
    logic                   found_next;
    logic [KIND_W-1:0]      kind_out_next;
    logic [SLOT_PORT_W-1:0] slot_out_next;
    logic                   evicted_next;

    logic            advance;
    logic            fire;
    logic [CMPW-1:0] cap_ext;
    logic [CMPW-1:0] eff_cap;
    logic            need_evict;
    logic [SW-1:0]   ins_slot;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign advance   = !m_valid_reg || m_ready;
    assign fire      = (state_reg == ST_EXEC) && advance;
    assign lru_cnt   = valid_cnt_reg - pinned_cnt_reg;

    // Broadcast the probe to the cell row
    assign prb.key        = key_reg;
    assign prb.unpin_mode = (op_reg == OP_UNPIN);
    assign prb.head_en    = (lru_cnt != '0);
    assign prb.slot_in    = slot_in_reg;
    assign prb.head_rank  = SW'(lru_cnt - CW'(1));

    for (genvar g = 0; g < NGRP; g++) begin : g_grp
        logic [$bits(chain_t)-1:0] word;
        plkc_grp #(
            .ENTRIES  (ENTRIES),
            .PIN_BITS (PIN_BITS),
            .BASE     (g * GRP)
        ) u_grp (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .probe    (prb),
            .cmd      (cm),
            .grp_word (word)
        );
        assign grp_word[g] = chain_t'(word);
    end

    // Merge the group words: lowest free slot, unique hit and head
    always_comb begin
        sel_next = '0;
        for (int g = 0; g < NGRP; g++) begin
            if (grp_word[g].free_any && !sel_next.free_any) begin
                sel_next.free_any = 1'b1;
                sel_next.free_idx = grp_word[g].free_idx;
            end
            sel_next.hit_any  = sel_next.hit_any | grp_word[g].hit_any;
            sel_next.hit_idx  = sel_next.hit_idx | grp_word[g].hit_idx;
            sel_next.hit_pin  = sel_next.hit_pin | grp_word[g].hit_pin;
            sel_next.hit_kind = sel_next.hit_kind | grp_word[g].hit_kind;
            sel_next.hit_rank = sel_next.hit_rank | grp_word[g].hit_rank;
            sel_next.head_any = sel_next.head_any | grp_word[g].head_any;
            sel_next.head_idx = sel_next.head_idx | grp_word[g].head_idx;
        end
    end

    always_ff @(posedge aclk) begin
        sel_reg <= sel_next;
    end

    // Clamp the capacity and decide whether an insert needs a victim
    assign cap_ext    = CMPW'(cap_reg);
    assign eff_cap    = (cap_ext == '0) ? CMPW'(1) :
                        (cap_ext > CMPW'(ENTRIES)) ? CMPW'(ENTRIES) : cap_ext;
    assign need_evict = (CMPW'(valid_cnt_reg) >= eff_cap);
    assign ins_slot   = !need_evict ? sel_reg.free_idx :
                        (sel_reg.free_any && (sel_reg.free_idx < sel_reg.head_idx)) ?
                        sel_reg.free_idx : sel_reg.head_idx;

    // Execute the operation: build the cell update and the result word
    always_comb begin
        cm              = '0;
        cm.go           = fire;
        cm.key          = key_reg;
        cm.kind         = kind_in_reg;
        status_next     = STAT_OK;
        found_next      = 1'b0;
        kind_out_next   = '0;
        slot_out_next   = '0;
        evicted_next    = 1'b0;
        valid_cnt_next  = valid_cnt_reg;
        pinned_cnt_next = pinned_cnt_reg;
        unique case (op_reg) inside
            OP_PIN, OP_SET: begin
                if (sel_reg.hit_any) begin
                    found_next  = 1'b1;
                    cm.tgt_slot = sel_reg.hit_idx;
                    if (op_reg == OP_PIN) begin
                        if (sel_reg.hit_pin == PIN_MAX) begin
                            status_next = STAT_PIN_SAT;
                        end else begin
                            cm.pin_en = 1'b1;
                            cm.pin    = sel_reg.hit_pin + PIN_BITS'(1);
                            if (sel_reg.hit_pin == '0) begin
                                cm.unlink_en    = 1'b1;
                                cm.unlink_rank  = sel_reg.hit_rank;
                                pinned_cnt_next = pinned_cnt_reg + CW'(1);
                            end
                        end
                    end else if (sel_reg.hit_pin == '0) begin
                        cm.unlink_en   = 1'b1;
                        cm.unlink_rank = sel_reg.hit_rank;
                        cm.append_en   = 1'b1;
                    end
                    if (status_next == STAT_OK) begin
                        cm.kind_en    = 1'b1;
                        kind_out_next = kind_in_reg;
                        slot_out_next = SLOT_PORT_W'(sel_reg.hit_idx);
                    end
                end else if (need_evict && !sel_reg.head_any) begin
                    status_next = STAT_ALL_PINNED;
                end else begin
                    if (need_evict) begin
                        evicted_next   = 1'b1;
                        cm.inval_en    = 1'b1;
                        cm.inval_slot  = sel_reg.head_idx;
                        cm.unlink_en   = 1'b1;
                        cm.unlink_rank = SW'(lru_cnt - CW'(1));
                    end else begin
                        valid_cnt_next = valid_cnt_reg + CW'(1);
                    end
                    cm.tgt_slot = ins_slot;
                    cm.ins_en   = 1'b1;
                    cm.kind_en  = 1'b1;
                    cm.pin_en   = 1'b1;
                    if (op_reg == OP_PIN) begin
                        cm.pin          = PIN_BITS'(1);
                        pinned_cnt_next = pinned_cnt_reg + CW'(1);
                    end else begin
                        cm.pin       = '0;
                        cm.append_en = 1'b1;
                    end
                    kind_out_next = kind_in_reg;
                    slot_out_next = SLOT_PORT_W'(ins_slot);
                end
            end
            OP_LOOKUP: begin
                if (sel_reg.hit_any) begin
                    found_next    = 1'b1;
                    cm.tgt_slot   = sel_reg.hit_idx;
                    kind_out_next = sel_reg.hit_kind;
                    slot_out_next = SLOT_PORT_W'(sel_reg.hit_idx);
                    if (sel_reg.hit_pin == '0) begin
                        cm.unlink_en   = 1'b1;
                        cm.unlink_rank = sel_reg.hit_rank;
                        cm.append_en   = 1'b1;
                    end
                end
            end
            OP_UNPIN: begin
                slot_out_next = slot_in_reg;
                if (!sel_reg.hit_any || (sel_reg.hit_pin == '0)) begin
                    status_next = STAT_BAD_UNPIN;
                end else begin
                    cm.tgt_slot   = sel_reg.hit_idx;
                    cm.pin_en     = 1'b1;
                    cm.pin        = sel_reg.hit_pin - PIN_BITS'(1);
                    kind_out_next = sel_reg.hit_kind;
                    if (sel_reg.hit_pin == PIN_BITS'(1)) begin
                        cm.append_en    = 1'b1;
                        pinned_cnt_next = pinned_cnt_reg - CW'(1);
                    end
                end
            end
            OP_FORGET: begin
                if (sel_reg.hit_any) begin
                    found_next    = 1'b1;
                    kind_out_next = sel_reg.hit_kind;
                    slot_out_next = SLOT_PORT_W'(sel_reg.hit_idx);
                    if (sel_reg.hit_pin != '0) begin
                        status_next = STAT_FORGET_PIN;
                    end else begin
                        cm.inval_en    = 1'b1;
                        cm.inval_slot  = sel_reg.hit_idx;
                        cm.unlink_en   = 1'b1;
                        cm.unlink_rank = sel_reg.hit_rank;
                        valid_cnt_next = valid_cnt_reg - CW'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Step the sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_valid) state_next = ST_MATCH;
            ST_MATCH: state_next = ST_SEL;
            ST_SEL:   state_next = ST_EXEC;
            ST_EXEC:  if (advance) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Hold control state, counts and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            valid_cnt_reg  <= '0;
            pinned_cnt_reg <= '0;
            cap_reg        <= CAP_RESET;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                cap_reg <= cfg_data;
            end
            if (fire) begin
                valid_cnt_reg  <= valid_cnt_next;
                pinned_cnt_reg <= pinned_cnt_next;
                m_valid_reg    <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the accepted word
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg      <= s_kind;
            key_reg     <= '{space: s_key_space, database: s_key_database,
                             relation: s_key_relation};
            kind_in_reg <= s_kind_in;
            slot_in_reg <= s_slot_in;
        end
    end

    // Load the result word
    always_ff @(posedge aclk) begin
        if (fire) begin
            status_reg   <= status_next;
            found_reg    <= found_next;
            kind_out_reg <= kind_out_next;
            slot_out_reg <= slot_out_next;
            evicted_reg  <= evicted_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = status_reg;
    assign m_found        = found_reg;
    assign m_kind_out     = kind_out_reg;
    assign m_slot_out     = slot_out_reg;
    assign m_evicted      = evicted_reg;
    assign m_occupancy    = CNT_PORT_W'(valid_cnt_reg);
    assign m_pinned_total = CNT_PORT_W'(pinned_cnt_reg);

`ifndef SYNTHESIS
    a_pinned_le_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        pinned_cnt_reg <= valid_cnt_reg)
        else $error("pinned count exceeds occupancy");

    a_valid_le_entries: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(valid_cnt_reg) <= ENTRIES)
        else $error("occupancy exceeds table size");

    a_result_from_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_EXEC))
        else $error("result word appeared outside execute");

    a_sel_after_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEL) |-> $past(state_reg == ST_MATCH))
        else $error("group merge entered out of order");
`endif

endmodule

### tb/tb.sv
// Testbench for pinned_lru_kind_cache_top: queue-fed driver, clocked monitor,
// and a behavioral predictor of the cache. Depends on plkc_pkg and the RTL.
module tb;
    import plkc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = 256;
    localparam int NIL   = 256;
    localparam int PMAX  = 255;

    typedef struct packed {
        logic [OP_W-1:0]        op;
        logic [KEY_W-1:0]       sp;
        logic [KEY_W-1:0]       db;
        logic [KEY_W-1:0]       rel;
        logic [KIND_W-1:0]      kin;
        logic [SLOT_PORT_W-1:0] sin;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0]      status;
        logic                   found;
        logic [KIND_W-1:0]      kout;
        logic [SLOT_PORT_W-1:0] slot;
        logic                   evicted;
        logic [CNT_PORT_W-1:0]  occ;
        logic [CNT_PORT_W-1:0]  pinned;
    } resp_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0, m_ready = 1'b0, cfg_valid = 1'b0;
    logic s_ready, m_valid, cfg_ready;
    logic [OP_W-1:0] s_kind = '0;
    logic [KEY_W-1:0] s_key_space = '0, s_key_database = '0, s_key_relation = '0;
    logic [KIND_W-1:0] s_kind_in = '0;
    logic [SLOT_PORT_W-1:0] s_slot_in = '0;
    logic [STAT_W-1:0] m_status;
    logic m_found, m_evicted;
    logic [KIND_W-1:0] m_kind_out;
    logic [SLOT_PORT_W-1:0] m_slot_out;
    logic [CNT_PORT_W-1:0] m_occupancy, m_pinned_total;
    logic [CAP_W-1:0] cfg_data = '0;

    pinned_lru_kind_cache_top i_dut (
        .aclk, .aresetn, .s_valid, .s_ready, .s_kind, .s_key_space, .s_key_database,
        .s_key_relation, .s_kind_in, .s_slot_in, .m_valid, .m_ready, .m_status,
        .m_found, .m_kind_out, .m_slot_out, .m_evicted, .m_occupancy, .m_pinned_total,
        .cfg_valid, .cfg_ready, .cfg_data
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // cache model state
    bit        c_valid [NSLOT];
    key_t      c_key [NSLOT];
    bit [1:0]  c_kind [NSLOT];
    int        c_pins [NSLOT];
    int        c_prev [NSLOT];
    int        c_next [NSLOT];
    int        lru_first, lru_last, n_valid, n_pinned;
    int        cap_reg;

    req_t  pending_words[$];
    resp_t expected_words[$];
    int    mismatches = 0;
    int    results_seen = 0;
    bit    hold_off = 1'b0;
    bit    tx_enable = 1'b1;

    function automatic void lru_remove(int s);
        int p, n;
        p = c_prev[s];
        n = c_next[s];
        if (p < NIL) c_next[p] = n; else lru_first = n;
        if (n < NIL) c_prev[n] = p; else lru_last = p;
        c_prev[s] = NIL;
        c_next[s] = NIL;
    endfunction

    function automatic void lru_push(int s);
        c_prev[s] = lru_last;
        c_next[s] = NIL;
        if (lru_last < NIL) c_next[lru_last] = s; else lru_first = s;
        lru_last = s;
    endfunction

    function automatic int key_slot(key_t k);
        for (int i = 0; i < NSLOT; i++)
            if (c_valid[i] && c_key[i] == k) return i;
        return NIL;
    endfunction

    function automatic void cache_reset();
        for (int i = 0; i < NSLOT; i++) begin
            c_valid[i] = 0; c_pins[i] = 0; c_kind[i] = 0;
            c_prev[i] = 0; c_next[i] = 0; c_key[i] = '0;
        end
        lru_first = NIL; lru_last = NIL; n_valid = 0; n_pinned = 0;
        cap_reg = CAP_RESET;
    endfunction

    // Compute the response word for one request and advance the model.
    function automatic resp_t cache_apply(req_t r);
        resp_t o;
        key_t  k;
        int    s, cap, v;
        o = '0;
        k = '{r.sp, r.db, r.rel};
        case (r.op)
            OP_PIN, OP_SET: begin
                s = key_slot(k);
                if (s < NIL) begin
                    o.found = 1;
                    if (r.op == OP_PIN) begin
                        if (c_pins[s] >= PMAX) o.status = STAT_PIN_SAT;
                        else begin
                            if (c_pins[s] == 0) begin lru_remove(s); n_pinned++; end
                            c_pins[s]++;
                        end
                    end else if (c_pins[s] == 0) begin
                        lru_remove(s); lru_push(s);
                    end
                    if (o.status == STAT_OK) begin
                        c_kind[s] = r.kin; o.kout = r.kin; o.slot = 8'(s);
                    end
                end else begin
                    cap = (cap_reg == 0) ? 1 : (cap_reg > NSLOT ? NSLOT : cap_reg);
                    if (n_valid >= cap) begin
                        if (lru_first >= NIL) o.status = STAT_ALL_PINNED;
                        else begin
                            v = lru_first; lru_remove(v);
                            c_valid[v] = 0; n_valid--; o.evicted = 1;
                        end
                    end
                    if (o.status == STAT_OK) begin
                        s = NIL;
                        for (int i = 0; i < NSLOT; i++)
                            if (!c_valid[i] && s == NIL) s = i;
                        c_valid[s] = 1; c_key[s] = k; c_kind[s] = r.kin;
                        c_pins[s] = (r.op == OP_PIN) ? 1 : 0;
                        if (r.op == OP_PIN) n_pinned++; else lru_push(s);
                        n_valid++;
                        o.slot = 8'(s); o.kout = r.kin;
                    end
                end
            end
            OP_LOOKUP: begin
                s = key_slot(k);
                if (s < NIL) begin
                    o.found = 1;
                    if (c_pins[s] == 0) begin lru_remove(s); lru_push(s); end
                    o.kout = c_kind[s]; o.slot = 8'(s);
                end
            end
            OP_UNPIN: begin
                s = r.sin;
                o.slot = r.sin;
                if (!c_valid[s] || c_pins[s] == 0) o.status = STAT_BAD_UNPIN;
                else begin
                    c_pins[s]--;
                    if (c_pins[s] == 0) begin n_pinned--; lru_push(s); end
                    o.kout = c_kind[s];
                end
            end
            OP_FORGET: begin
                s = key_slot(k);
                if (s < NIL) begin
                    o.found = 1; o.kout = c_kind[s]; o.slot = 8'(s);
                    if (c_pins[s] != 0) o.status = STAT_FORGET_PIN;
                    else begin
                        lru_remove(s); c_valid[s] = 0; n_valid--;
                    end
                end
            end
            default: ;
        endcase
        o.occ = 9'(n_valid);
        o.pinned = 9'(n_pinned);
        return o;
    endfunction

    // driver: burst/gap pacing, hold payload until accepted
    int burst_left = 0, gap_left = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_words.push_back(cache_apply('{s_kind, s_key_space,
                    s_key_database, s_key_relation, s_kind_in, s_slot_in}));
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) gap_left <= gap_left - 1;
                if (tx_enable && gap_left == 0 && pending_words.size() > 0) begin
                    req_t w;
                    w = pending_words.pop_front();
                    s_valid <= 1'b1;
                    s_kind <= w.op; s_key_space <= w.sp; s_key_database <= w.db;
                    s_key_relation <= w.rel; s_kind_in <= w.kin; s_slot_in <= w.sin;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 30);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stall pattern
    int stall_phase = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            stall_phase <= stall_phase + 1;
            m_ready <= !hold_off && ((stall_phase % 64) < 40 || $urandom_range(0, 2) == 0);
            if (m_valid && m_ready) begin
                resp_t got, want;
                got = '{m_status, m_found, m_kind_out, m_slot_out, m_evicted,
                        m_occupancy, m_pinned_total};
                results_seen <= results_seen + 1;
                if (expected_words.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) $display("unexpected result word %h", got);
                end else begin
                    want = expected_words.pop_front();
                    if (got !== want) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch: exp st%0d f%0d k%0d sl%0d ev%0d oc%0d pn%0d",
                                want.status, want.found, want.kout, want.slot, want.evicted,
                                want.occ, want.pinned,
                                ", got st%0d f%0d k%0d sl%0d ev%0d oc%0d pn%0d",
                                got.status, got.found, got.kout,
                                got.slot, got.evicted, got.occ, got.pinned);
                    end
                end
            end
        end
    end

    // key pool keeps hit rates high; each key is distinct
    key_t key_pool[48];

    function automatic req_t mk(logic [2:0] op, key_t k, logic [1:0] kin, logic [7:0] sl);
        return '{op, k.space, k.database, k.relation, kin, sl};
    endfunction

    function automatic key_t pick_key();
        if ($urandom_range(0, 9) == 0)
            return '{$urandom(), $urandom(), $urandom()};
        return key_pool[$urandom_range(0, 47)];
    endfunction

    task automatic drain();
        wait (pending_words.size() == 0 && !s_valid);
        wait (expected_words.size() == 0);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_cap(logic [CAP_W-1:0] v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cap_reg = v;
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(int n);
        key_t       k;
        int         r;
        logic [1:0] kr;
        logic [7:0] sr;
        for (int i = 0; i < n; i++) begin
            k = pick_key();
            r = $urandom_range(0, 99);
            kr = 2'($urandom());
            sr = 8'($urandom());
            if (r < 30) pending_words.push_back(mk(OP_PIN, k, kr, sr));
            else if (r < 50) pending_words.push_back(mk(OP_LOOKUP, k, kr, sr));
            else if (r < 68) pending_words.push_back(mk(OP_SET, k, kr, sr));
            else if (r < 88) begin
                if ($urandom_range(0, 3) != 0) sr = 8'($urandom_range(0, 40));
                pending_words.push_back(mk(OP_UNPIN, k, kr, sr));
            end
            else if (r < 97) pending_words.push_back(mk(OP_FORGET, k, kr, sr));
            else pending_words.push_back(mk(3'($urandom_range(5, 7)), k, kr, sr));
        end
    endtask

    initial begin
        key_t kmax, kzero;
        cache_reset();
        for (int i = 0; i < 48; i++) key_pool[i] = '{$urandom(), $urandom(), i};
        kmax = '1;
        kzero = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, every op, error cases
        pending_words.push_back(mk(OP_LOOKUP, kmax, 2'd3, 8'hff));
        pending_words.push_back(mk(OP_FORGET, kmax, 2'd0, 8'h00));
        pending_words.push_back(mk(OP_UNPIN, kzero, 2'd0, 8'hff));
        pending_words.push_back(mk(OP_PIN, kmax, 2'd3, 8'h00));
        pending_words.push_back(mk(OP_SET, kzero, 2'd2, 8'h00));
        pending_words.push_back(mk(OP_PIN, kmax, 2'd1, 8'h00));
        pending_words.push_back(mk(OP_FORGET, kmax, 2'd0, 8'h00));
        pending_words.push_back(mk(OP_SET, kmax, 2'd0, 8'h00));
        pending_words.push_back(mk(OP_UNPIN, kzero, 2'd0, 8'h00));
        pending_words.push_back(mk(OP_UNPIN, kzero, 2'd0, 8'h00));
        pending_words.push_back(mk(OP_UNPIN, kzero, 2'd0, 8'h00));
        pending_words.push_back(mk(OP_UNPIN, kzero, 2'd0, 8'h01));
        pending_words.push_back(mk(OP_LOOKUP, kzero, 2'd0, 8'h00));
        pending_words.push_back(mk(OP_FORGET, kzero, 2'd0, 8'h00));
        pending_words.push_back(mk(3'd5, kmax, 2'd3, 8'hff));
        pending_words.push_back(mk(3'd7, kmax, 2'd3, 8'hff));
        drain();

        // pin saturation: one key pinned to the top, then release it
        for (int i = 0; i < PMAX + 1; i++)
            pending_words.push_back(mk(OP_PIN, key_pool[0], i[1:0], 8'h00));
        drain();
        for (int i = 0; i < PMAX; i++)
            pending_words.push_back(mk(OP_UNPIN, kzero, 2'd0, 8'h01));
        drain();

        // capacity 0 acts as 1; all pinned case
        write_cap(9'd0);
        pending_words.push_back(mk(OP_PIN, key_pool[1], 2'd1, 8'h00));
        pending_words.push_back(mk(OP_PIN, key_pool[2], 2'd1, 8'h00));
        pending_words.push_back(mk(OP_SET, key_pool[3], 2'd2, 8'h00));
        random_phase(40);
        drain();

        // capacity 3 with long receiver hold-off to back up the block
        write_cap(9'd3);
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge aclk);
                hold_off = 1'b0;
            end
        join_none
        random_phase(80);
        drain();

        // over-range capacity, then capacity 16, then maximum values
        write_cap(9'h1ff);
        random_phase(60);
        drain();
        write_cap(9'd16);
        random_phase(80);
        drain();
        write_cap(9'd256);
        random_phase(60);
        drain();

        if (mismatches == 0 && expected_words.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end
endmodule
